// File: src/rri_pkg.sv
package rri_pkg;

    // Coordinate format: signed Q8.12 at the default width.
    localparam int COORD_BITS = 20;
    localparam int EPS_BITS   = 24;
    localparam int TQ_FRAC    = 16;
    localparam int TQ_W       = 32;

    // Configuration port.
    localparam int CFG_W     = 3 * COORD_BITS;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ORIGIN     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_EDGE_A_END = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_EDGE_B_END = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NORMAL      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_HIT_EPSILON       = CFG_IDX_W'(4);

    localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(16777);

    // Datapath widths.
    localparam int REL_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * COORD_BITS + 2;
    localparam int DOT_W  = 2 * COORD_BITS + 3;
    localparam int MW     = DOT_W + 1;
    localparam int PH     = MW / 2;
    localparam int WW     = 2 * MW;
    localparam int UW     = DOT_W - 1;

    // Queue between the classifier and the divider.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One classified ray waiting for its division.
    typedef struct packed {
        logic          hit;
        logic [UW-1:0] num;
        logic [UW-1:0] den;
    } cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Partial products of one wide signed multiplication.
    typedef struct packed {
        logic [2*PH+1:0] hh;
        logic [2*PH+1:0] hl;
        logic [2*PH+1:0] lh;
        logic [2*PH-1:0] ll;
    } pp_t;

    function automatic logic signed [COORD_BITS-1:0] coord(input logic [CFG_W-1:0] r,
                                                           input int i);
        return r[i*COORD_BITS +: COORD_BITS];
    endfunction

    // Splits a by b into four half-width products.
    function automatic pp_t split_mul(input logic signed [MW-1:0] a,
                                      input logic signed [MW-1:0] b);
        logic signed [PH-1:0]   ah;
        logic signed [PH-1:0]   bh;
        logic [PH-1:0]          al;
        logic [PH-1:0]          bl;
        logic signed [2*PH+1:0] hh;
        logic signed [2*PH+1:0] hl;
        logic signed [2*PH+1:0] lh;
        pp_t                    p;
        ah = a[MW-1:PH];
        al = a[PH-1:0];
        bh = b[MW-1:PH];
        bl = b[PH-1:0];
        hh = ah * bh;
        hl = ah * $signed({1'b0, bl});
        lh = $signed({1'b0, al}) * bh;
        p.hh = hh;
        p.hl = hl;
        p.lh = lh;
        p.ll = al * bl;
        return p;
    endfunction

    // Adds the partial products back into the full product.
    function automatic logic signed [WW-1:0] join_mul(input pp_t p);
        logic signed [WW-1:0] r;
        r = ($signed(WW'($signed(p.hh))) <<< (2 * PH))
          + ($signed(WW'($signed(p.hl))) <<< PH)
          + ($signed(WW'($signed(p.lh))) <<< PH)
          + $signed(WW'(p.ll));
        return r;
    endfunction

endpackage

// File: src/ray_rectangle_intersect.sv
// Ray against rectangle test, one ray per beat.
// Configuration: write corner zero, the two corners that end the edges, the
// plane normal and the tolerance through cfg_we, cfg_index and cfg_data while
// no ray is in flight. A write at an unused index is ignored.
// Input channel: in_valid and in_stall carry a ray (origin and direction,
// signed Q8.12). Output channel: out_valid and out_stall carry hit and
// hit_distance (unsigned Q16.16, saturating, zero on a miss).
// Throughput is one ray per cycle while in_stall is low. A ray passes eight
// classifier stages (the first loads at the accepting edge), the queue, a
// divider of 33 stages that resolves one quotient bit from each stage to the
// next, and the output register.
// A four-entry queue separates the classifier from the divider. When the
// receiver stalls, the divider holds; the classifier keeps accepting rays until
// the queue is full, and only then raises in_stall.
// Reset clears all valid state and the queue and loads the register defaults:
// zero geometry and a tolerance of 16777.
module ray_rectangle_intersect (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rri_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rri_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rri_pkg::COORD_BITS-1:0] origin_x,
    input  logic signed [rri_pkg::COORD_BITS-1:0] origin_y,
    input  logic signed [rri_pkg::COORD_BITS-1:0] origin_z,
    input  logic signed [rri_pkg::COORD_BITS-1:0] dir_x,
    input  logic signed [rri_pkg::COORD_BITS-1:0] dir_y,
    input  logic signed [rri_pkg::COORD_BITS-1:0] dir_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit,
    output logic [rri_pkg::TQ_W-1:0]              hit_distance
);
    import rri_pkg::*;

    qstat_t q_stat;
    logic   push;
    logic   pop;
    cls_t   push_entry;
    cls_t   pop_entry;

    // Classifier.
    rri_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue between the two halves.
    rri_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    // Distance divider and output register.
    rri_divider u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop          (pop),
        .pop_entry    (pop_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_distance (hit_distance)
    );

`ifndef SYNTH
    // The input side only stalls when the queue has no room.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_stat.full)
        else $error("input stalled while the queue had room");

    // A miss always reports a zero distance.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (hit_distance == '0))
        else $error("miss with a nonzero distance");

    // At most one entry leaves per cycle, so a full queue is not empty next.
    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |=> !q_stat.empty)
        else $error("queue drained faster than one entry per cycle");
`endif

endmodule

// File: src/rri_front.sv
module rri_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rri_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rri_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rri_pkg::COORD_BITS-1:0] origin_x,
    input  logic signed [rri_pkg::COORD_BITS-1:0] origin_y,
    input  logic signed [rri_pkg::COORD_BITS-1:0] origin_z,
    input  logic signed [rri_pkg::COORD_BITS-1:0] dir_x,
    input  logic signed [rri_pkg::COORD_BITS-1:0] dir_y,
    input  logic signed [rri_pkg::COORD_BITS-1:0] dir_z,
    input  rri_pkg::qstat_t                       q_stat,
    output logic                                  push,
    output rri_pkg::cls_t                         push_entry
);
    import rri_pkg::*;

    localparam int P_ED = 0;
    localparam int P_RA = 1;
    localparam int P_NA = 2;
    localparam int P_RB = 3;
    localparam int P_NB = 4;
    localparam int P_LA = 5;
    localparam int P_LB = 6;
    localparam int NPROD = 7;

    logic [CFG_W-1:0]    corner_origin_reg;
    logic [CFG_W-1:0]    corner_edge_a_end_reg;
    logic [CFG_W-1:0]    corner_edge_b_end_reg;
    logic [CFG_W-1:0]    plane_normal_reg;
    logic [EPS_BITS-1:0] hit_epsilon_reg;

    logic signed [COORD_BITS-1:0] p0 [3];
    logic signed [COORD_BITS-1:0] nv [3];
    logic signed [REL_W-1:0]      ea [3];
    logic signed [REL_W-1:0]      eb [3];
    logic signed [REL_W-1:0]      rel [3];

    logic signed [DOT_W-1:0] la_reg, la_next;
    logic signed [DOT_W-1:0] lb_reg, lb_next;

    logic f_en;
    logic [7:0] v_reg;

    logic signed [COORD_BITS-1:0] s0_o_reg [3];
    logic signed [COORD_BITS-1:0] s0_d_reg [3];

    logic signed [PROD_W-1:0] s1_rn_reg [3], s1_rn_next [3];
    logic signed [PROD_W-1:0] s1_dn_reg [3], s1_dn_next [3];
    logic signed [PROD_W-1:0] s1_ra_reg [3], s1_ra_next [3];
    logic signed [PROD_W-1:0] s1_rb_reg [3], s1_rb_next [3];
    logic signed [PROD_W-1:0] s1_da_reg [3], s1_da_next [3];
    logic signed [PROD_W-1:0] s1_db_reg [3], s1_db_next [3];

    logic signed [DOT_W-1:0] s2_num_reg, s2_num_next;
    logic signed [DOT_W-1:0] s2_den_reg, s2_den_next;
    logic signed [DOT_W-1:0] s2_rda_reg, s2_rda_next;
    logic signed [DOT_W-1:0] s2_rdb_reg, s2_rdb_next;
    logic signed [DOT_W-1:0] s2_dda_reg, s2_dda_next;
    logic signed [DOT_W-1:0] s2_ddb_reg, s2_ddb_next;

    logic signed [DOT_W-1:0] s3_num_reg, s3_den_reg;
    logic signed [DOT_W-1:0] s3_rda_reg, s3_rdb_reg, s3_dda_reg, s3_ddb_reg;
    logic                    s3_zero_reg;

    pp_t                     s4_pp_reg [NPROD];
    pp_t                     s4_pp_next [NPROD];
    logic signed [DOT_W-1:0] s4_num_reg, s4_den_reg;
    logic                    s4_zero_reg;

    logic signed [WW-1:0]    s5_prod_reg [NPROD];
    logic signed [DOT_W-1:0] s5_num_reg, s5_den_reg;
    logic                    s5_zero_reg;

    logic signed [WW-1:0]    s6_xa_reg, s6_xb_reg, s6_ed_reg, s6_la_reg, s6_lb_reg;
    logic signed [WW-1:0]    s6_nsh_reg;
    logic signed [DOT_W-1:0] s6_num_reg, s6_den_reg;
    logic                    s6_zero_reg;

    cls_t s7_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_origin_reg     <= '0;
            corner_edge_a_end_reg <= '0;
            corner_edge_b_end_reg <= '0;
            plane_normal_reg      <= '0;
            hit_epsilon_reg       <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CORNER_ORIGIN:     corner_origin_reg     <= cfg_data;
                REG_CORNER_EDGE_A_END: corner_edge_a_end_reg <= cfg_data;
                REG_CORNER_EDGE_B_END: corner_edge_b_end_reg <= cfg_data;
                REG_PLANE_NORMAL:      plane_normal_reg      <= cfg_data;
                REG_HIT_EPSILON:       hit_epsilon_reg       <= cfg_data[EPS_BITS-1:0];
                default:               ;
            endcase
        end
    end

    // Rectangle geometry and the squared edge lengths.
    always_comb
    begin
        logic signed [COORD_BITS-1:0] p1 [3];
        logic signed [COORD_BITS-1:0] p3 [3];
        logic signed [PROD_W-1:0]     ta;
        logic signed [PROD_W-1:0]     tb;
        la_next = '0;
        lb_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            p0[i] = coord(corner_origin_reg, i);
            p1[i] = coord(corner_edge_a_end_reg, i);
            p3[i] = coord(corner_edge_b_end_reg, i);
            nv[i] = coord(plane_normal_reg, i);
            ea[i] = p1[i] - p0[i];
            eb[i] = p3[i] - p0[i];
            ta = ea[i] * ea[i];
            tb = eb[i] * eb[i];
            la_next = la_next + DOT_W'(ta);
            lb_next = lb_next + DOT_W'(tb);
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg <= la_next;
        lb_reg <= lb_next;
    end

    // The whole classifier advances unless its last beat cannot enter the queue.
    assign f_en       = !v_reg[7] || !q_stat.full;
    assign in_stall   = !f_en;
    assign push       = v_reg[7] && !q_stat.full;
    assign push_entry = s7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (f_en)
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    // Stage one products and stage two dot products.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rel[i]        = p0[i] - s0_o_reg[i];
            s1_rn_next[i] = rel[i] * nv[i];
            s1_dn_next[i] = s0_d_reg[i] * nv[i];
            s1_ra_next[i] = rel[i] * ea[i];
            s1_rb_next[i] = rel[i] * eb[i];
            s1_da_next[i] = s0_d_reg[i] * ea[i];
            s1_db_next[i] = s0_d_reg[i] * eb[i];
        end
        s2_num_next = '0;
        s2_den_next = '0;
        s2_rda_next = '0;
        s2_rdb_next = '0;
        s2_dda_next = '0;
        s2_ddb_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            s2_num_next = s2_num_next + DOT_W'(s1_rn_reg[i]);
            s2_den_next = s2_den_next + DOT_W'(s1_dn_reg[i]);
            s2_rda_next = s2_rda_next - DOT_W'(s1_ra_reg[i]);
            s2_rdb_next = s2_rdb_next - DOT_W'(s1_rb_reg[i]);
            s2_dda_next = s2_dda_next + DOT_W'(s1_da_reg[i]);
            s2_ddb_next = s2_ddb_next + DOT_W'(s1_db_reg[i]);
        end
    end

    // Stage four splits the wide products into half-width pieces.
    always_comb
    begin
        logic signed [MW-1:0] num_m;
        logic signed [MW-1:0] den_m;
        logic signed [MW-1:0] eps_m;
        num_m = s3_num_reg;
        den_m = s3_den_reg;
        eps_m = MW'(hit_epsilon_reg);
        s4_pp_next[P_ED] = split_mul(eps_m, den_m);
        s4_pp_next[P_RA] = split_mul(MW'(s3_rda_reg), den_m);
        s4_pp_next[P_NA] = split_mul(num_m, MW'(s3_dda_reg));
        s4_pp_next[P_RB] = split_mul(MW'(s3_rdb_reg), den_m);
        s4_pp_next[P_NB] = split_mul(num_m, MW'(s3_ddb_reg));
        s4_pp_next[P_LA] = split_mul(MW'(la_reg), den_m);
        s4_pp_next[P_LB] = split_mul(MW'(lb_reg), den_m);
    end

    // Datapath registers of all classifier stages.
    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            s0_o_reg[0] <= origin_x;
            s0_o_reg[1] <= origin_y;
            s0_o_reg[2] <= origin_z;
            s0_d_reg[0] <= dir_x;
            s0_d_reg[1] <= dir_y;
            s0_d_reg[2] <= dir_z;

            s1_rn_reg <= s1_rn_next;
            s1_dn_reg <= s1_dn_next;
            s1_ra_reg <= s1_ra_next;
            s1_rb_reg <= s1_rb_next;
            s1_da_reg <= s1_da_next;
            s1_db_reg <= s1_db_next;

            s2_num_reg <= s2_num_next;
            s2_den_reg <= s2_den_next;
            s2_rda_reg <= s2_rda_next;
            s2_rdb_reg <= s2_rdb_next;
            s2_dda_reg <= s2_dda_next;
            s2_ddb_reg <= s2_ddb_next;

            // Make the denominator positive.
            s3_num_reg  <= s2_den_reg[DOT_W-1] ? -s2_num_reg : s2_num_reg;
            s3_den_reg  <= s2_den_reg[DOT_W-1] ? -s2_den_reg : s2_den_reg;
            s3_zero_reg <= (s2_den_reg == '0);
            s3_rda_reg  <= s2_rda_reg;
            s3_rdb_reg  <= s2_rdb_reg;
            s3_dda_reg  <= s2_dda_reg;
            s3_ddb_reg  <= s2_ddb_reg;

            s4_pp_reg   <= s4_pp_next;
            s4_num_reg  <= s3_num_reg;
            s4_den_reg  <= s3_den_reg;
            s4_zero_reg <= s3_zero_reg;

            for (int k = 0; k < NPROD; k++)
            begin
                s5_prod_reg[k] <= join_mul(s4_pp_reg[k]);
            end
            s5_num_reg  <= s4_num_reg;
            s5_den_reg  <= s4_den_reg;
            s5_zero_reg <= s4_zero_reg;

            s6_xa_reg   <= s5_prod_reg[P_RA] + s5_prod_reg[P_NA];
            s6_xb_reg   <= s5_prod_reg[P_RB] + s5_prod_reg[P_NB];
            s6_ed_reg   <= s5_prod_reg[P_ED];
            s6_la_reg   <= s5_prod_reg[P_LA];
            s6_lb_reg   <= s5_prod_reg[P_LB];
            s6_nsh_reg  <= WW'(s5_num_reg) <<< EPS_BITS;
            s6_num_reg  <= s5_num_reg;
            s6_den_reg  <= s5_den_reg;
            s6_zero_reg <= s5_zero_reg;

            // Distance above tolerance and hit point inside both edges.
            s7_reg.hit <= !s6_zero_reg
                       && (s6_ed_reg < s6_nsh_reg)
                       && (s6_xa_reg >= -s6_ed_reg) && (s6_xa_reg <= s6_la_reg)
                       && (s6_xb_reg >= -s6_ed_reg) && (s6_xb_reg <= s6_lb_reg);
            s7_reg.num <= s6_num_reg[UW-1:0];
            s7_reg.den <= s6_den_reg[UW-1:0];
        end
    end

endmodule

// File: src/rri_queue.sv
module rri_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rri_pkg::cls_t   push_entry,
    input  logic            pop,
    output rri_pkg::cls_t   pop_entry,
    output rri_pkg::qstat_t q_stat
);
    import rri_pkg::*;

    cls_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_entry    = mem[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/rri_divider.sv
module rri_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rri_pkg::qstat_t            q_stat,
    output logic                       pop,
    input  rri_pkg::cls_t              pop_entry,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [rri_pkg::TQ_W-1:0]   hit_distance
);
    import rri_pkg::*;

    localparam int NSTG = TQ_W + 1;
    localparam int SHW  = UW + TQ_W - TQ_FRAC;

    logic back_en;

    logic            d_valid_reg [NSTG];
    logic            d_hit_reg   [NSTG];
    logic            d_sat_reg   [NSTG];
    logic [UW-1:0]   d_den_reg   [NSTG];
    logic [UW-1:0]   d_rem_reg   [NSTG];
    logic [TQ_W-1:0] d_nlow_reg  [NSTG];
    logic [TQ_W-1:0] d_q_reg     [NSTG];

    logic [UW-1:0]   rem_next  [TQ_W];
    logic [TQ_W-1:0] q_next    [TQ_W];

    logic            out_valid_reg;
    logic            hit_reg;
    logic [TQ_W-1:0] dist_reg;

    assign back_en      = !out_valid_reg || !out_stall;
    assign pop          = back_en && !q_stat.empty;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;

    // One quotient bit per stage, restoring division.
    always_comb
    begin
        logic [UW:0] trial;
        logic        ge;
        for (int k = 0; k < TQ_W; k++)
        begin
            trial       = {d_rem_reg[k], d_nlow_reg[k][TQ_W-1]};
            ge          = (trial >= {1'b0, d_den_reg[k]});
            rem_next[k] = ge ? UW'(trial - {1'b0, d_den_reg[k]}) : UW'(trial);
            q_next[k]   = {d_q_reg[k][TQ_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            d_valid_reg[0] <= !q_stat.empty;
            for (int k = 1; k < NSTG; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
            out_valid_reg <= d_valid_reg[NSTG-1];
        end
    end

    // Divider datapath and the output register.
    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            d_hit_reg[0]  <= pop_entry.hit;
            d_sat_reg[0]  <= (SHW'(pop_entry.num) >= (SHW'(pop_entry.den) << (TQ_W - TQ_FRAC)));
            d_den_reg[0]  <= pop_entry.den;
            d_rem_reg[0]  <= UW'(pop_entry.num >> (TQ_W - TQ_FRAC));
            d_nlow_reg[0] <= TQ_W'(pop_entry.num[TQ_FRAC-1:0]) << (TQ_W - TQ_FRAC);
            d_q_reg[0]    <= '0;
            for (int k = 1; k < NSTG; k++)
            begin
                d_hit_reg[k]  <= d_hit_reg[k-1];
                d_sat_reg[k]  <= d_sat_reg[k-1];
                d_den_reg[k]  <= d_den_reg[k-1];
                d_rem_reg[k]  <= rem_next[k-1];
                d_nlow_reg[k] <= d_nlow_reg[k-1] << 1;
                d_q_reg[k]    <= q_next[k-1];
            end
            hit_reg <= d_hit_reg[NSTG-1];
            if (!d_hit_reg[NSTG-1])
            begin
                dist_reg <= '0;
            end
            else if (d_sat_reg[NSTG-1])
            begin
                dist_reg <= '1;
            end
            else
            begin
                dist_reg <= d_q_reg[NSTG-1];
            end
        end
    end

endmodule

// File: tb/tb.sv
module tb;
    import rri_pkg::*;

    // Coordinate type and accepted ray beat.
    typedef logic signed [COORD_BITS-1:0] crd_t;

    typedef struct {
        crd_t ox;
        crd_t oy;
        crd_t oz;
        crd_t dx;
        crd_t dy;
        crd_t dz;
    } ray_t;

    typedef struct {
        logic        hit;
        logic [31:0] dist_val;
    } hitres_t;

    // Scoreboard: predicts the hit result of each accepted ray and checks the outputs.
    class hit_scoreboard;
        logic [CFG_W-1:0]    p0_reg;
        logic [CFG_W-1:0]    p1_reg;
        logic [CFG_W-1:0]    p3_reg;
        logic [CFG_W-1:0]    n_reg;
        logic [EPS_BITS-1:0] eps_reg;
        hitres_t             pending[$];
        int                  errors;
        int                  hits;
        int                  checked;

        function new();
            p0_reg = '0;
            p1_reg = '0;
            p3_reg = '0;
            n_reg = '0;
            eps_reg = EPS_RESET;
            errors = 0;
            hits = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            unique case (idx)
                REG_CORNER_ORIGIN:     p0_reg = v;
                REG_CORNER_EDGE_A_END: p1_reg = v;
                REG_CORNER_EDGE_B_END: p3_reg = v;
                REG_PLANE_NORMAL:      n_reg = v;
                REG_HIT_EPSILON:       eps_reg = v[EPS_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint part(logic [CFG_W-1:0] r, int i);
            crd_t c;
            c = r[i*COORD_BITS +: COORD_BITS];
            return longint'(c);
        endfunction

        // Works out the result of one ray with exact wide arithmetic.
        function hitres_t predict(ray_t r);
            longint o[3], d[3], rel[3], ea[3], eb[3], nv[3];
            longint num, den, rda, rdb, dda, ddb, la, lb, eps;
            logic signed [159:0] lower, xa, xb, tq;
            hitres_t res;
            o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
            d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
            for (int i = 0; i < 3; i++)
            begin
                rel[i] = part(p0_reg, i) - o[i];
                ea[i] = part(p1_reg, i) - part(p0_reg, i);
                eb[i] = part(p3_reg, i) - part(p0_reg, i);
                nv[i] = part(n_reg, i);
            end
            res.hit = 1'b0;
            res.dist_val = '0;
            eps = longint'(eps_reg);
            num = rel[0]*nv[0] + rel[1]*nv[1] + rel[2]*nv[2];
            den = d[0]*nv[0] + d[1]*nv[1] + d[2]*nv[2];
            if (den == 0)
                return res;
            if (den < 0)
            begin
                num = -num;
                den = -den;
            end
            if ((160'(eps) * 160'(den)) >= ($signed(160'(num)) <<< EPS_BITS))
                return res;
            rda = -(rel[0]*ea[0] + rel[1]*ea[1] + rel[2]*ea[2]);
            rdb = -(rel[0]*eb[0] + rel[1]*eb[1] + rel[2]*eb[2]);
            dda = d[0]*ea[0] + d[1]*ea[1] + d[2]*ea[2];
            ddb = d[0]*eb[0] + d[1]*eb[1] + d[2]*eb[2];
            la = ea[0]*ea[0] + ea[1]*ea[1] + ea[2]*ea[2];
            lb = eb[0]*eb[0] + eb[1]*eb[1] + eb[2]*eb[2];
            lower = -($signed(160'(eps)) * $signed(160'(den)));
            xa = $signed(160'(rda)) * $signed(160'(den))
               + $signed(160'(num)) * $signed(160'(dda));
            xb = $signed(160'(rdb)) * $signed(160'(den))
               + $signed(160'(num)) * $signed(160'(ddb));
            if (xa < lower || xa > $signed(160'(la)) * $signed(160'(den)))
                return res;
            if (xb < lower || xb > $signed(160'(lb)) * $signed(160'(den)))
                return res;
            tq = ($signed(160'(num)) <<< TQ_FRAC) / $signed(160'(den));
            res.hit = 1'b1;
            res.dist_val = (tq > 160'sh0FFFFFFFF) ? 32'hFFFFFFFF : tq[31:0];
            return res;
        endfunction

        function void note_ray(ray_t r);
            pending.insert(pending.size(), predict(r));
        endfunction

        function void check_result(logic h, logic [31:0] act_dist);
            hitres_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected: hit=%0d dist=%h", h, act_dist);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.hit)
                hits++;
            if (h !== e.hit)
            begin
                $error("hit: expected %0d, actual %0d", e.hit, h);
                errors++;
            end
            if (act_dist !== e.dist_val)
            begin
                $error("hit_distance: expected %h, actual %h", e.dist_val, act_dist);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    crd_t                   origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic                   out_valid;
    logic                   out_stall;
    logic                   hit;
    logic [TQ_W-1:0]        hit_distance;

    hit_scoreboard sb;
    int            cycle_count;
    int            rays_sent;
    bit            out_calm;

    ray_rectangle_intersect u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .hit_distance(hit_distance)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, checks every beat taken.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(hit, hit_distance);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (!out_calm && $urandom_range(0, 3) == 0)
            begin
                hold = gap_len();
                out_stall <= (hold > 0);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one ray and waits until it is taken.
    task automatic send_ray(ray_t r);
        in_valid <= 1'b1;
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_ray(r);
        rays_sent++;
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n)
                @(posedge clk);
        end
    endtask

    // Drops in_valid, waits for every outstanding result and then idles before returning.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
    endtask

    // One register write, then the write enable is dropped before the task returns.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pack3(crd_t x, crd_t y, crd_t z);
        return {z, y, x};
    endfunction

    function automatic crd_t rnd_crd(int span);
        if (span == 0)
            return crd_t'($urandom());
        return crd_t'($signed($urandom_range(0, 2*span)) - span);
    endfunction

    // Square of side sz in a random axis-aligned plane at a random position, tolerance by eps_mode.
    task automatic setup_rect(int sz, int eps_mode);
        int   ax;
        crd_t c0, c1, c2, off, nrm;
        ax = $urandom_range(0, 2);
        c0 = rnd_crd(8192);
        c1 = rnd_crd(8192);
        off = rnd_crd(16384);
        c2 = c0 + crd_t'(sz);
        nrm = ($urandom_range(0, 1) != 0) ? crd_t'(4096) : -crd_t'(4096);
        unique case (ax)
            0:
            begin
                write_reg(REG_CORNER_ORIGIN, pack3(off, c0, c1));
                write_reg(REG_CORNER_EDGE_A_END, pack3(off, c2, c1));
                write_reg(REG_CORNER_EDGE_B_END, pack3(off, c0, c1 + crd_t'(sz)));
                write_reg(REG_PLANE_NORMAL, pack3(nrm, 0, 0));
            end
            1:
            begin
                write_reg(REG_CORNER_ORIGIN, pack3(c0, off, c1));
                write_reg(REG_CORNER_EDGE_A_END, pack3(c2, off, c1));
                write_reg(REG_CORNER_EDGE_B_END, pack3(c0, off, c1 + crd_t'(sz)));
                write_reg(REG_PLANE_NORMAL, pack3(0, nrm, 0));
            end
            default:
            begin
                write_reg(REG_CORNER_ORIGIN, pack3(c0, c1, off));
                write_reg(REG_CORNER_EDGE_A_END, pack3(c2, c1, off));
                write_reg(REG_CORNER_EDGE_B_END, pack3(c0, c1 + crd_t'(sz), off));
                write_reg(REG_PLANE_NORMAL, pack3(0, 0, nrm));
            end
        endcase
        unique case (eps_mode)
            0: write_reg(REG_HIT_EPSILON, '0);
            1: write_reg(REG_HIT_EPSILON, CFG_W'(24'hFFFFFF));
            default: write_reg(REG_HIT_EPSILON, CFG_W'($urandom_range(0, 70000)));
        endcase
    endtask

    // Ray aimed near the rectangle from a random origin, or pure noise.
    function automatic ray_t aim_ray();
        ray_t r;
        crd_t p[3], tgt[3], o[3];
        int   k;
        if ($urandom_range(0, 9) == 0)
        begin
            r.ox = rnd_crd(0); r.oy = rnd_crd(0); r.oz = rnd_crd(0);
            r.dx = rnd_crd(0); r.dy = rnd_crd(0); r.dz = rnd_crd(0);
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            p[i] = sb.p0_reg[i*COORD_BITS +: COORD_BITS];
            tgt[i] = p[i] + rnd_crd(12000);
            o[i] = tgt[i] + rnd_crd(60000);
        end
        k = $urandom_range(1, 4);
        r.ox = o[0]; r.oy = o[1]; r.oz = o[2];
        r.dx = crd_t'((tgt[0] - o[0]) / k);
        r.dy = crd_t'((tgt[1] - o[1]) / k);
        r.dz = crd_t'((tgt[2] - o[2]) / k);
        if ($urandom_range(0, 19) == 0)
            r.dx = 0;
        return r;
    endfunction

    initial
    begin
        ray_t r;
        crd_t ext[4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        cycle_count = 0;
        rays_sent = 0;
        out_calm = 1'b0;
        sb = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: zero normal, every ray parallel.
        r = '{default: crd_t'(0)};
        send_ray(r);
        r = '{crd_t'(-524288), crd_t'(524287), 0, crd_t'(524287), crd_t'(-524288), 1};
        send_ray(r);
        drain();

        // Directed: unit square in z = 0, rays hitting, missing, parallel,
        // behind, at the edges, and saturated distance.
        write_reg(REG_CORNER_ORIGIN, pack3(0, 0, 0));
        write_reg(REG_CORNER_EDGE_A_END, pack3(4096, 0, 0));
        write_reg(REG_CORNER_EDGE_B_END, pack3(0, 4096, 0));
        write_reg(REG_PLANE_NORMAL, pack3(0, 0, 4096));
        write_reg(REG_HIT_EPSILON, CFG_W'(EPS_RESET));
        write_reg(CFG_IDX_W'(7), '1);
        send_ray('{2048, 2048, 8192, 0, 0, -4096});
        send_ray('{2048, 2048, 8192, 0, 0, 4096});
        send_ray('{2048, 2048, 8192, 4096, 0, 0});
        send_ray('{8192, 2048, 8192, 0, 0, -4096});
        send_ray('{0, 0, 4096, 0, 0, -4096});
        send_ray('{4096, 4096, 4096, 0, 0, -4096});
        send_ray('{4097, 4096, 4096, 0, 0, -4096});
        send_ray('{2048, 2048, 0, 0, 0, -4096});
        send_ray('{2048, 2048, 524287, 0, 0, -1});
        send_ray('{2048, 2048, -524288, 0, 0, 524287});
        send_ray('{2048, 2048, 4096, 1, -1, -524288});
        ext = '{crd_t'(-524288), crd_t'(524287), crd_t'(-1), crd_t'(0)};
        for (int i = 0; i < 8; i++)
            send_ray('{ext[i%4], ext[(i+1)%4], ext[(i+2)%4],
                       ext[(i+3)%4], ext[i%4], ext[(i+1)%4]});
        drain();

        // Extreme registers: all ones, then extreme corners.
        write_reg(REG_CORNER_ORIGIN, '1);
        write_reg(REG_CORNER_EDGE_A_END, pack3(crd_t'(524287), crd_t'(524287), 0));
        write_reg(REG_CORNER_EDGE_B_END, pack3(crd_t'(-524288), 0, crd_t'(524287)));
        write_reg(REG_PLANE_NORMAL, pack3(crd_t'(-524288), crd_t'(524287), crd_t'(-524288)));
        write_reg(REG_HIT_EPSILON, CFG_W'(24'hFFFFFF));
        for (int i = 0; i < 6; i++)
        begin
            r.ox = rnd_crd(0); r.oy = rnd_crd(0); r.oz = rnd_crd(0);
            r.dx = rnd_crd(0); r.dy = rnd_crd(0); r.dz = rnd_crd(0);
            send_ray(r);
        end
        drain();

        // Random phases with different rectangles and tolerances.
        for (int ph = 0; ph < 11; ph++)
        begin
            if (ph == 5)
                setup_rect(0, 2);
            else
                setup_rect($urandom_range(0, 3) == 0 ? 524287 : $urandom_range(1, 40000),
                           ph % 3);
            out_calm = (ph == 3);
            for (int i = 0; i < 100; i++)
            begin
                if (i == 50 && ph == 7)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
                if (ph != 3 && $urandom_range(0, 2) == 0)
                    idle_cycles(gap_len());
                send_ray(aim_ray());
            end
            drain();
        end
        out_calm = 1'b0;

        $display("Sent %0d rays over several rectangles and tolerances;", rays_sent);
        $display("%0d results checked, %0d of them hits.", sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
